[rtl/ced_pkg.sv]
// ----------------------------------------------------------------------------
// ced_pkg: shared types and constants for the escape decoder
// Beat payloads, the decoder result bundle, the mode encoding and the
// escape letter map.
// ----------------------------------------------------------------------------
package ced_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } esc_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } dec_beat_t;

    typedef struct packed {
        logic      have;
        dec_beat_t beat;
    } dec_result_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_ESC     = 5'b00010,
        MODE_OCT1    = 5'b00100,
        MODE_OCT2    = 5'b01000,
        MODE_DISCARD = 5'b10000
    } mode_t;

    localparam logic [7:0] BACKSLASH   = 8'h5c;
    localparam logic [4:0] OCTAL_UPPER = 5'b00110;

    function automatic logic is_octal(input logic [7:0] b);
        is_octal = (b[7:3] == OCTAL_UPPER);
    endfunction

    function automatic logic [7:0] map_escaped(input logic [7:0] b);
        logic [7:0] code;
        begin
            case (b)
                8'h61:   code = 8'd7;
                8'h62:   code = 8'd8;
                8'h74:   code = 8'd9;
                8'h6e:   code = 8'd10;
                8'h76:   code = 8'd11;
                8'h66:   code = 8'd12;
                8'h72:   code = 8'd13;
                default: code = b;
            endcase
            map_escaped = code;
        end
    endfunction

endpackage

[rtl/c_escape_decoder.sv]
// ----------------------------------------------------------------------------
// c_escape_decoder: C string escape decoder
// Decodes backslash escapes one byte per beat, with an error flag on the
// final result of a malformed string.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the input is not stalled. An
// accepted byte is held in the input register, and the escape state machine
// loads its result into the result register when the byte advances.
// Bytes that only open or extend an escape produce no result beat; the final
// byte of a string always produces exactly one beat with last set. Input
// stalls only while the input register holds a byte with a result and the
// result register is full and stalled.
module c_escape_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               esc_valid,
    output logic               esc_stall,
    input  ced_pkg::esc_beat_t esc_data,
    output logic               dec_valid,
    input  logic               dec_stall,
    output ced_pkg::dec_beat_t dec_data
);
    import ced_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    esc_beat_t   s1_item_reg;
    dec_result_t res;
    logic        out_free;
    logic        advance;
    logic        take;

    assign advance   = s1_valid_reg && (!res.have || out_free);
    assign esc_stall = s1_valid_reg && !advance;
    assign take      = esc_valid && !esc_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= esc_data;
        end
    end

    ced_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (s1_item_reg),
        .step  (advance),
        .res   (res)
    );

    ced_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res.have),
        .load_beat (res.beat),
        .free      (out_free),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_data  (dec_data)
    );

endmodule

[rtl/ced_decode.sv]
// ----------------------------------------------------------------------------
// ced_decode: escape state machine
// Holds the mode and octal accumulator and forms the result for the beat
// presented on item; state advances when step is high.
// ----------------------------------------------------------------------------
module ced_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ced_pkg::esc_beat_t   item,
    input  logic                 step,
    output ced_pkg::dec_result_t res
);
    import ced_pkg::*;

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [7:0] acc_reg;
    logic [7:0] acc_next;

    logic [7:0] b;
    logic [2:0] digit;
    logic       octal;
    logic       have;
    logic       fault;
    logic       err;
    logic [7:0] value;

    assign b     = item.in_byte;
    assign digit = b[2:0];
    assign octal = is_octal(b);

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        have      = 1'b0;
        fault     = 1'b0;
        value     = 8'd0;
        case (mode_reg)
            MODE_ESC:
            begin
                if (octal)
                begin
                    acc_next  = {digit[1:0], 6'd0};
                    mode_next = MODE_OCT1;
                end
                else
                begin
                    value     = map_escaped(b);
                    have      = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_OCT1:
            begin
                if (octal)
                begin
                    acc_next  = acc_reg + {2'd0, digit, 3'd0};
                    mode_next = MODE_OCT2;
                end
                else
                begin
                    fault = 1'b1;
                end
            end
            MODE_OCT2:
            begin
                if (octal)
                begin
                    value     = acc_reg + {5'd0, digit};
                    have      = 1'b1;
                    acc_next  = 8'd0;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    fault = 1'b1;
                end
            end
            MODE_DISCARD:
            begin
                fault = 1'b1;
            end
            default:
            begin
                if (b == BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    value     = b;
                    have      = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
        endcase

        if (fault)
        begin
            mode_next = MODE_DISCARD;
            acc_next  = 8'd0;
        end
        if (item.end_of_string)
        begin
            mode_next = MODE_IDLE;
            acc_next  = 8'd0;
        end
    end

    assign err = fault || !have;

    always_comb
    begin
        res.have          = have || item.end_of_string;
        res.beat.out_byte = (item.end_of_string && err) ? 8'd0 : value;
        res.beat.last     = item.end_of_string;
        res.beat.error    = item.end_of_string && err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 8'd0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

[rtl/ced_out_reg.sv]
// ----------------------------------------------------------------------------
// ced_out_reg: result register
// Holds one decoded beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module ced_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  ced_pkg::dec_beat_t load_beat,
    output logic               free,
    output logic               dec_valid,
    input  logic               dec_stall,
    output ced_pkg::dec_beat_t dec_data
);
    import ced_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    dec_beat_t data_reg;

    assign free = !valid_reg || !dec_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!dec_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_beat;
        end
    end

    assign dec_valid = valid_reg;
    assign dec_data  = data_reg;

endmodule

[rtl/ced_checker.sv]
// ----------------------------------------------------------------------------
// ced_checker: port checks for the escape decoder
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module ced_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               esc_valid,
    input logic               esc_stall,
    input ced_pkg::esc_beat_t esc_data,
    input logic               dec_valid,
    input logic               dec_stall,
    input ced_pkg::dec_beat_t dec_data
);
    import ced_pkg::*;

    a_in_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        esc_valid && esc_stall |=> esc_valid && $stable(esc_data))
        else $error("stalled input beat changed");

    a_error_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_data.error |-> dec_data.last)
        else $error("error beat without last");

    a_error_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_data.error |-> dec_data.out_byte == 8'd0)
        else $error("error beat carries a byte");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_stall |=> dec_valid && $stable(dec_data))
        else $error("stalled result beat changed");

endmodule

bind c_escape_decoder ced_checker u_ced_checker (.*);
